/* hw/rtl/ppd_pkg.sv */
package ppd_pkg;

   localparam int unsigned DIV_W      = 32;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PRESENCE_LEVEL   = 3'd0,
      CSR_MIN_RATE         = 3'd1,
      CSR_MAX_RATE         = 3'd2,
      CSR_REFRACTORY_GAP   = 3'd3,
      CSR_RECALC_PERIOD    = 3'd4,
      CSR_MIN_FILL         = 3'd5
   } csr_index_type;

   localparam logic [15:0] RST_PRESENCE_LEVEL   = 16'd5000;
   localparam logic [7:0]  RST_MIN_RATE         = 8'd30;
   localparam logic [7:0]  RST_MAX_RATE         = 8'd220;
   localparam logic [5:0]  RST_REFRACTORY_GAP   = 6'd5;
   localparam logic [5:0]  RST_RECALC_PERIOD    = 6'd5;
   localparam logic [5:0]  RST_MIN_FILL         = 6'd10;

   localparam logic [DIV_W-1:0] BPM_NUMERATOR = 32'd60000;
   localparam int LAST_PEAK_INIT = -10;

   typedef struct packed {
      logic [15:0] presence_level;
      logic [7:0]  min_rate;
      logic [7:0]  max_rate;
      logic [5:0]  refractory_gap;
      logic [5:0]  recalc_period;
      logic [5:0]  min_fill;
   } cfg_type;

   typedef struct packed {
      logic [15:0] ir_level;
      logic [31:0] time_ms;
      logic        present;
   } item_type;

   typedef struct packed {
      logic [7:0] pulse_bpm;
      logic       finger_present;
      logic       recalculated;
   } result_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DIV_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic             busy;
      logic [DIV_W-1:0] quotient;
      logic [DIV_W-1:0] remainder;
   } div_rsp_type;

endpackage

/* hw/rtl/ppd_if.sv */
interface ppd_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] ir_level;
   logic [31:0] time_ms;

   modport source (output valid, output ir_level, output time_ms, input ready);
   modport sink   (input valid, input ir_level, input time_ms, output ready);
endinterface

interface ppd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] pulse_bpm;
   logic       finger_present;
   logic       recalculated;

   modport source (output valid, output pulse_bpm, output finger_present,
                   output recalculated, input ready);
   modport sink   (input valid, input pulse_bpm, input finger_present,
                   input recalculated, output ready);
endinterface

/* hw/rtl/ppd_divider.sv */
module ppd_divider (
   input  logic                clock,
   input  logic                reset,
   input  ppd_pkg::div_req_type req,
   output ppd_pkg::div_rsp_type rsp
);

   localparam int unsigned DW = ppd_pkg::DIV_W;
   localparam int unsigned NW = $clog2(DW);

   logic          busy_ff;
   logic          done_ff;
   logic [NW-1:0] cnt_ff;
   logic [DW-1:0] quo_ff;
   logic [DW-1:0] rem_ff;
   logic [DW-1:0] dvs_ff;
   logic [DW:0]   trial;
   logic [DW:0]   diff;
   logic          fits;

   assign trial = {rem_ff, quo_ff[DW-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (!busy_ff && req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            quo_ff  <= req.dividend;
            rem_ff  <= '0;
            dvs_ff  <= req.divisor;
         end else if (busy_ff) begin
            // one quotient bit per cycle, restoring
            quo_ff <= {quo_ff[DW-2:0], fits};
            rem_ff <= fits ? diff[DW-1:0] : trial[DW-1:0];
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == NW'(DW - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign rsp.done      = done_ff;
   assign rsp.busy      = busy_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff;

endmodule

/* hw/rtl/ppd_front.sv */
module ppd_front (
   input  logic               clock,
   input  logic               reset,
   input  logic [15:0]        presence_level,
   ppd_req_if.sink            req_if,
   output logic               push_valid,
   output ppd_pkg::item_type  push_item,
   input  logic               push_ready
);

   logic              valid_ff;
   ppd_pkg::item_type item_ff;

   assign req_if.ready = !valid_ff || push_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            valid_ff         <= 1'b1;
            item_ff.ir_level <= req_if.ir_level;
            item_ff.time_ms  <= req_if.time_ms;
            item_ff.present  <= req_if.ir_level > presence_level;
         end else if (push_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   assign push_valid = valid_ff;
   assign push_item  = item_ff;

endmodule

/* hw/rtl/ppd_queue.sv */
module ppd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  ppd_pkg::item_type push_item,
   output logic              push_ready,
   output logic              pop_valid,
   output ppd_pkg::item_type pop_item,
   input  logic              pop_ready
);

   localparam int unsigned DEPTH = 2;

   ppd_pkg::item_type slot_ff [DEPTH];
   logic       wr_ff;
   logic       rd_ff;
   logic [1:0] cnt_ff;
   logic       push;
   logic       pop;

   assign push_ready = cnt_ff != 2'(DEPTH);
   assign pop_valid  = cnt_ff != 2'd0;
   assign pop_item   = slot_ff[rd_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) begin
            slot_ff[wr_ff] <= push_item;
            wr_ff          <= ~wr_ff;
         end
         if (pop) begin
            rd_ff <= ~rd_ff;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 2'd1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 2'd1;
         end
      end
   end

endmodule

/* hw/rtl/ppd_back.sv */
module ppd_back #(
   parameter int unsigned WINDOW_DEPTH = 60,
   parameter int unsigned MAX_PEAKS    = 20
) (
   input  logic                clock,
   input  logic                reset,
   input  ppd_pkg::cfg_type    cfg,
   input  logic                q_valid,
   input  ppd_pkg::item_type   q_item,
   output logic                q_pop,
   input  logic                out_ready,
   output logic                out_valid,
   output ppd_pkg::result_type out_data
);

   localparam int unsigned AW = $clog2(WINDOW_DEPTH);
   localparam int unsigned CW = $clog2(WINDOW_DEPTH + 1);
   localparam int unsigned SW = 16 + CW;
   localparam int unsigned LW = CW + 3;
   localparam int unsigned PW = $clog2(MAX_PEAKS + 1);
   localparam int unsigned MW = (CW > 6) ? CW : 6;
   localparam int unsigned DW = ppd_pkg::DIV_W;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MOD_START,
      S_MOD_WAIT,
      S_SUM,
      S_MEAN_START,
      S_MEAN_WAIT,
      S_PEAK,
      S_PEAK_END,
      S_AVG_WAIT,
      S_BPM_WAIT,
      S_OUT
   } state_type;

   logic [15:0] sample_mem [WINDOW_DEPTH];
   logic [31:0] time_mem   [WINDOW_DEPTH];

   state_type           state_ff;
   logic [AW-1:0]       ptr_ff;
   logic [CW-1:0]       fill_ff;
   logic [7:0]          rate_ff;
   logic                recalc_ff;
   logic                present_ff;
   logic [AW-1:0]       start_ff;
   logic [AW-1:0]       rd_addr_ff;
   logic [CW-1:0]       iss_cnt_ff;
   logic [CW-1:0]       rcv_cnt_ff;
   logic                rd_vld_ff;
   logic [15:0]         rd_lvl_ff;
   logic [31:0]         rd_time_ff;
   logic [SW-1:0]       sum_ff;
   logic [15:0]         mean_ff;
   logic [15:0]         prev1_ff;
   logic [15:0]         prev2_ff;
   logic [31:0]         prev1_t_ff;
   logic signed [LW-1:0] last_ff;
   logic [PW-1:0]       npk_ff;
   logic [31:0]         first_t_ff;
   logic [31:0]         last_t_ff;
   logic                out_valid_ff;
   ppd_pkg::result_type out_ff;

   ppd_pkg::div_req_type div_req;
   ppd_pkg::div_rsp_type div_rsp;

   logic [5:0]           period;
   logic [CW-1:0]        fill_in;
   logic [AW-1:0]        ptr_in;
   logic [AW-1:0]        rd_addr_in;
   logic [CW:0]          ptr_x;
   logic [CW:0]          fill_x;
   logic [CW:0]          start_x;
   logic                 issuing;
   logic                 last_rcv;
   logic [CW-1:0]        cand_idx;
   logic signed [LW-1:0] gap_diff;
   logic                 is_peak;
   logic                 enough_fill;
   logic [15:0]          bpm;
   logic                 bpm_ok;
   logic                 out_free;

   ppd_divider u_divider (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign period  = (cfg.recalc_period == 6'd0) ? 6'd1 : cfg.recalc_period;
   assign fill_in = (fill_ff == CW'(WINDOW_DEPTH)) ? fill_ff : fill_ff + 1'b1;
   assign ptr_in  = (ptr_ff == AW'(WINDOW_DEPTH - 1)) ? '0 : ptr_ff + 1'b1;
   assign rd_addr_in = (rd_addr_ff == AW'(WINDOW_DEPTH - 1)) ? '0 : rd_addr_ff + 1'b1;

   // oldest entry of the filled part of the window
   assign ptr_x   = (CW + 1)'(ptr_ff);
   assign fill_x  = (CW + 1)'(fill_ff);
   assign start_x = (ptr_x >= fill_x) ? ptr_x - fill_x
                                      : ptr_x + (CW + 1)'(WINDOW_DEPTH) - fill_x;

   assign issuing  = ((state_ff == S_SUM) || (state_ff == S_PEAK)) && (iss_cnt_ff < fill_ff);
   assign last_rcv = rd_vld_ff && (rcv_cnt_ff == fill_ff - 1'b1);

   // candidate is the sample before the one arriving now
   assign cand_idx = rcv_cnt_ff - 1'b1;
   assign gap_diff = $signed(LW'(cand_idx)) - last_ff;
   assign is_peak  = rd_vld_ff && (rcv_cnt_ff >= CW'(2)) && (prev1_ff > mean_ff) &&
                     (prev1_ff > prev2_ff) && (prev1_ff > rd_lvl_ff) &&
                     (gap_diff >= $signed(LW'(cfg.refractory_gap)));

   assign enough_fill = MW'(fill_ff) >= MW'(cfg.min_fill);
   assign bpm         = div_rsp.quotient[15:0];
   assign bpm_ok      = (bpm != 16'd0) && (bpm >= 16'(cfg.min_rate)) &&
                        (bpm <= 16'(cfg.max_rate));
   assign out_free    = !out_valid_ff || out_ready;
   assign q_pop       = (state_ff == S_IDLE) && q_valid;

   always_comb begin
      div_req = '0;
      case (state_ff)
         S_MOD_START: begin
            div_req.start    = 1'b1;
            div_req.dividend = DW'(fill_ff);
            div_req.divisor  = DW'(period);
         end
         S_MEAN_START: begin
            div_req.start    = 1'b1;
            div_req.dividend = DW'(sum_ff);
            div_req.divisor  = DW'(fill_ff);
         end
         S_PEAK_END: begin
            div_req.start    = npk_ff >= PW'(2);
            div_req.dividend = last_t_ff - first_t_ff;
            div_req.divisor  = DW'(npk_ff) - 1'b1;
         end
         S_AVG_WAIT: begin
            div_req.start    = div_rsp.done && (div_rsp.quotient != '0);
            div_req.dividend = ppd_pkg::BPM_NUMERATOR;
            div_req.divisor  = div_rsp.quotient;
         end
         default: begin
            div_req = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (q_pop && q_item.present) begin
         sample_mem[ptr_ff] <= q_item.ir_level;
         time_mem[ptr_ff]   <= q_item.time_ms;
      end
      if (issuing) begin
         rd_lvl_ff  <= sample_mem[rd_addr_ff];
         rd_time_ff <= time_mem[rd_addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ptr_ff       <= '0;
         fill_ff      <= '0;
         rate_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         rd_vld_ff <= issuing;
         if (out_valid_ff && out_ready && (state_ff != S_OUT)) begin
            out_valid_ff <= 1'b0;
         end
         if (issuing) begin
            rd_addr_ff <= rd_addr_in;
            iss_cnt_ff <= iss_cnt_ff + 1'b1;
         end
         case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  present_ff <= q_item.present;
                  recalc_ff  <= 1'b0;
                  if (q_item.present) begin
                     ptr_ff   <= ptr_in;
                     fill_ff  <= fill_in;
                     state_ff <= S_MOD_START;
                  end else begin
                     // no finger: drop the window and the held rate
                     ptr_ff   <= '0;
                     fill_ff  <= '0;
                     rate_ff  <= '0;
                     state_ff <= S_OUT;
                  end
               end
            end
            S_MOD_START: begin
               state_ff <= S_MOD_WAIT;
            end
            S_MOD_WAIT: begin
               if (div_rsp.done) begin
                  if (div_rsp.remainder == '0) begin
                     recalc_ff <= 1'b1;
                     if (enough_fill) begin
                        start_ff   <= start_x[AW-1:0];
                        rd_addr_ff <= start_x[AW-1:0];
                        iss_cnt_ff <= '0;
                        rcv_cnt_ff <= '0;
                        sum_ff     <= '0;
                        state_ff   <= S_SUM;
                     end else begin
                        state_ff <= S_OUT;
                     end
                  end else begin
                     state_ff <= S_OUT;
                  end
               end
            end
            S_SUM: begin
               if (rd_vld_ff) begin
                  sum_ff     <= sum_ff + SW'(rd_lvl_ff);
                  rcv_cnt_ff <= rcv_cnt_ff + 1'b1;
               end
               if (last_rcv) begin
                  state_ff <= S_MEAN_START;
               end
            end
            S_MEAN_START: begin
               state_ff <= S_MEAN_WAIT;
            end
            S_MEAN_WAIT: begin
               if (div_rsp.done) begin
                  mean_ff    <= div_rsp.quotient[15:0];
                  rd_addr_ff <= start_ff;
                  iss_cnt_ff <= '0;
                  rcv_cnt_ff <= '0;
                  last_ff    <= LW'(ppd_pkg::LAST_PEAK_INIT);
                  npk_ff     <= '0;
                  state_ff   <= S_PEAK;
               end
            end
            S_PEAK: begin
               if (rd_vld_ff) begin
                  prev2_ff   <= prev1_ff;
                  prev1_ff   <= rd_lvl_ff;
                  prev1_t_ff <= rd_time_ff;
                  rcv_cnt_ff <= rcv_cnt_ff + 1'b1;
               end
               if (is_peak) begin
                  // a peak past the limit still restarts the gap
                  last_ff <= $signed(LW'(cand_idx));
                  if (npk_ff < PW'(MAX_PEAKS)) begin
                     if (npk_ff == '0) begin
                        first_t_ff <= prev1_t_ff;
                     end
                     last_t_ff <= prev1_t_ff;
                     npk_ff    <= npk_ff + 1'b1;
                  end
               end
               if (last_rcv) begin
                  state_ff <= S_PEAK_END;
               end
            end
            S_PEAK_END: begin
               state_ff <= (npk_ff >= PW'(2)) ? S_AVG_WAIT : S_OUT;
            end
            S_AVG_WAIT: begin
               if (div_rsp.done) begin
                  state_ff <= (div_rsp.quotient != '0) ? S_BPM_WAIT : S_OUT;
               end
            end
            S_BPM_WAIT: begin
               if (div_rsp.done) begin
                  if (bpm_ok) begin
                     rate_ff <= bpm[7:0];
                  end
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (out_free) begin
                  out_valid_ff          <= 1'b1;
                  out_ff.pulse_bpm      <= rate_ff;
                  out_ff.finger_present <= present_ff;
                  out_ff.recalculated   <= recalc_ff;
                  state_ff              <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

`ifndef SYNTHESIS
   a_ptr_tracks_fill: assert property (@(posedge clock) disable iff (reset)
      (fill_ff < CW'(WINDOW_DEPTH)) |-> (ptr_ff == fill_ff[AW-1:0]))
      else $error("write pointer out of step with fill count");

   a_no_finger_clears: assert property (@(posedge clock) disable iff (reset)
      (q_pop && !q_item.present) |=> (fill_ff == '0 && rate_ff == '0))
      else $error("no-finger item did not clear state");

   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy)
      else $error("divider started while busy");

   a_recalc_needs_finger: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.recalculated |-> out_ff.finger_present)
      else $error("recalculation flagged without finger");
`endif

endmodule

/* hw/rtl/pulse_rate_peak_detector_top.sv */
// Heart-rate estimator over infrared pulse samples: one result item per input item,
// carrying the held rate, the finger flag and whether the fill count hit a multiple
// of the recalculation period. An item with no finger clears the window and the held
// rate. An item with a finger but no recalculation still waits for the remainder of
// the fill count by the recalculation period on the shared serial divider.
// A recalculation over a fill count of N at least the minimum fill makes two passes
// over the window memory at one entry per cycle (sum, then peak search) plus up to
// three more divisions (mean, average interval, 60000 / interval). Items queue in front
// of the compute engine, and the result register frees the engine while a result waits.
module pulse_rate_peak_detector_top #(
   parameter int unsigned WINDOW_DEPTH = 60,
   parameter int unsigned MAX_PEAKS    = 20
) (
   input  logic                             clock,
   input  logic                             reset,
   ppd_req_if.sink                          req_if,
   ppd_rsp_if.source                        rsp_if,
   input  logic                             csr_we,
   input  logic [ppd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ppd_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   ppd_pkg::cfg_type    cfg_ff;
   logic                push_valid;
   logic                push_ready;
   ppd_pkg::item_type   push_item;
   logic                pop_valid;
   logic                pop_ready;
   ppd_pkg::item_type   pop_item;
   ppd_pkg::result_type out_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.presence_level   <= ppd_pkg::RST_PRESENCE_LEVEL;
         cfg_ff.min_rate         <= ppd_pkg::RST_MIN_RATE;
         cfg_ff.max_rate         <= ppd_pkg::RST_MAX_RATE;
         cfg_ff.refractory_gap   <= ppd_pkg::RST_REFRACTORY_GAP;
         cfg_ff.recalc_period    <= ppd_pkg::RST_RECALC_PERIOD;
         cfg_ff.min_fill         <= ppd_pkg::RST_MIN_FILL;
      end else if (csr_we) begin
         case (csr_index)
            ppd_pkg::CSR_PRESENCE_LEVEL:   cfg_ff.presence_level   <= csr_wdata;
            ppd_pkg::CSR_MIN_RATE:         cfg_ff.min_rate         <= csr_wdata[7:0];
            ppd_pkg::CSR_MAX_RATE:         cfg_ff.max_rate         <= csr_wdata[7:0];
            ppd_pkg::CSR_REFRACTORY_GAP:   cfg_ff.refractory_gap   <= csr_wdata[5:0];
            ppd_pkg::CSR_RECALC_PERIOD:    cfg_ff.recalc_period    <= csr_wdata[5:0];
            ppd_pkg::CSR_MIN_FILL:         cfg_ff.min_fill         <= csr_wdata[5:0];
            default: begin
            end
         endcase
      end
   end

   ppd_front u_front (
      .clock          (clock),
      .reset          (reset),
      .presence_level (cfg_ff.presence_level),
      .req_if         (req_if),
      .push_valid     (push_valid),
      .push_item      (push_item),
      .push_ready     (push_ready)
   );

   ppd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop_ready  (pop_ready)
   );

   ppd_back #(
      .WINDOW_DEPTH (WINDOW_DEPTH),
      .MAX_PEAKS    (MAX_PEAKS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (pop_valid),
      .q_item    (pop_item),
      .q_pop     (pop_ready),
      .out_ready (rsp_if.ready),
      .out_valid (rsp_if.valid),
      .out_data  (out_data)
   );

   assign rsp_if.pulse_bpm      = out_data.pulse_bpm;
   assign rsp_if.finger_present = out_data.finger_present;
   assign rsp_if.recalculated   = out_data.recalculated;

endmodule

/* verif/pulse_rate_peak_detector_top_test.sv */
`timescale 1ns / 100ps

module pulse_rate_peak_detector_top_test;

   localparam int unsigned DEPTH     = 60;
   localparam int unsigned PEAK_SLOTS = 20;

   typedef struct {
      logic [15:0]         ir_level;
      logic [31:0]         time_ms;
      bit                  typed;
      ppd_pkg::result_type want;
   } stim_row_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [ppd_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [ppd_pkg::CSR_DATA_W-1:0] csr_wdata;

   ppd_req_if req_if();
   ppd_rsp_if rsp_if();

   pulse_rate_peak_detector_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor copy of the configuration and state
   ppd_pkg::cfg_type    pcfg;
   logic [15:0]         level_mem [DEPTH];
   logic [31:0]         stamp_mem [DEPTH];
   int unsigned         wr_ptr;
   int unsigned         fill;
   logic [7:0]          rate_hold;

   ppd_pkg::result_type rate_queue [$];
   stim_row_type        stim_rows [$];

   int unsigned  errors;
   int unsigned  items_sent;
   int unsigned  results_seen;
   int unsigned  recalc_seen;
   int unsigned  rate_seen;
   bit           idle_on;
   bit           hold_request;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("%0t: timeout with %0d results outstanding", $time, rate_queue.size());
      $display("CHECK FAILED");
      $finish;
   end

   function automatic logic [7:0] estimate_bpm();
      int unsigned lvl [DEPTH];
      int unsigned stamp [DEPTH];
      int unsigned peak_t [PEAK_SLOTS];
      int unsigned sum, mean, npk, total, avg, bpm, idx;
      int          last;
      sum = 0;
      npk = 0;
      total = 0;
      last = -10;
      if (fill < pcfg.min_fill || fill > DEPTH) return 8'd0;
      for (int unsigned i = 0; i < fill; i++) begin
         idx = (wr_ptr + DEPTH - fill + i) % DEPTH;
         lvl[i] = level_mem[idx];
         stamp[i] = stamp_mem[idx];
         sum += lvl[i];
      end
      mean = sum / fill;
      for (int unsigned i = 1; i + 1 < fill; i++) begin
         if (lvl[i] > mean && lvl[i] > lvl[i-1] && lvl[i] > lvl[i+1] &&
             (int'(i) - last) >= int'(pcfg.refractory_gap)) begin
            if (npk < PEAK_SLOTS) begin
               peak_t[npk] = stamp[i];
               npk++;
            end
            last = int'(i);
         end
      end
      if (npk < 2) return 8'd0;
      for (int unsigned i = 1; i < npk; i++) total += peak_t[i] - peak_t[i-1];
      avg = total / (npk - 1);
      if (avg == 0) return 8'd0;
      bpm = 60000 / avg;
      if (bpm < pcfg.min_rate || bpm > pcfg.max_rate) return 8'd0;
      return bpm[7:0];
   endfunction

   function automatic ppd_pkg::result_type predict_rate(logic [15:0] ir, logic [31:0] tm);
      ppd_pkg::result_type r;
      int unsigned         period;
      logic [7:0]          bpm;
      r = '0;
      if (ir > pcfg.presence_level) begin
         period = (pcfg.recalc_period == 0) ? 1 : pcfg.recalc_period;
         r.finger_present = 1'b1;
         level_mem[wr_ptr] = ir;
         stamp_mem[wr_ptr] = tm;
         wr_ptr = (wr_ptr + 1) % DEPTH;
         if (fill < DEPTH) fill++;
         if (fill % period == 0) begin
            r.recalculated = 1'b1;
            bpm = estimate_bpm();
            if (bpm != 0) rate_hold = bpm;
         end
      end else begin
         wr_ptr = 0;
         fill = 0;
         rate_hold = 8'd0;
      end
      r.pulse_bpm = rate_hold;
      return r;
   endfunction

   // drive one register write; the caller drops the write enable afterwards
   task automatic write_csr(ppd_pkg::csr_index_type idx, int unsigned value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[ppd_pkg::CSR_DATA_W-1:0];
      case (idx)
         ppd_pkg::CSR_PRESENCE_LEVEL: pcfg.presence_level = value[15:0];
         ppd_pkg::CSR_MIN_RATE:       pcfg.min_rate = value[7:0];
         ppd_pkg::CSR_MAX_RATE:       pcfg.max_rate = value[7:0];
         ppd_pkg::CSR_REFRACTORY_GAP: pcfg.refractory_gap = value[5:0];
         ppd_pkg::CSR_RECALC_PERIOD:  pcfg.recalc_period = value[5:0];
         ppd_pkg::CSR_MIN_FILL:       pcfg.min_fill = value[5:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      while (rate_queue.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_config(int unsigned thr, int unsigned lo, int unsigned hi,
                             int unsigned gap, int unsigned period, int unsigned need);
      drain();
      write_csr(ppd_pkg::CSR_PRESENCE_LEVEL, thr);
      write_csr(ppd_pkg::CSR_MIN_RATE, lo);
      write_csr(ppd_pkg::CSR_MAX_RATE, hi);
      write_csr(ppd_pkg::CSR_REFRACTORY_GAP, gap);
      write_csr(ppd_pkg::CSR_RECALC_PERIOD, period);
      write_csr(ppd_pkg::CSR_MIN_FILL, need);
      csr_we <= 1'b0;
   endtask

   // offer one item and book its expected result at acceptance
   task automatic send_item(logic [15:0] ir, logic [31:0] tm, bit typed,
                            ppd_pkg::result_type want);
      int unsigned         gap;
      ppd_pkg::result_type r;
      gap = idle_on ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.ir_level <= ir;
      req_if.time_ms <= tm;
      do @(posedge clock); while (!req_if.ready);
      r = predict_rate(ir, tm);
      rate_queue.push_back(typed ? want : r);
      items_sent++;
   endtask

   task automatic add_row(logic [15:0] ir, logic [31:0] tm, bit typed,
                          logic [7:0] bpm, logic present, logic recalc);
      stim_row_type row;
      row.ir_level = ir;
      row.time_ms = tm;
      row.typed = typed;
      row.want.pulse_bpm = bpm;
      row.want.finger_present = present;
      row.want.recalculated = recalc;
      stim_rows.push_back(row);
   endtask

   // pulse trains with random content, mixed with noise and dropouts
   task automatic run_stream(int unsigned count);
      int unsigned n, len, period, step, base, amp, half, ramp, lvl;
      logic [31:0] tm;
      n = 0;
      while (n < count) begin
         case ($urandom_range(0, 9))
            0: begin
               send_item(16'($urandom), $urandom, 1'b0, '0);
               n++;
            end
            1: begin
               send_item(16'($urandom_range(0, pcfg.presence_level)), $urandom, 1'b0, '0);
               n++;
            end
            default: begin
               len = $urandom_range(12, 70);
               period = $urandom_range(2, 16);
               half = (period / 2 == 0) ? 1 : period / 2;
               step = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 400);
               base = pcfg.presence_level + 1 + $urandom_range(0, 2000);
               amp = $urandom_range(0, 8000);
               tm = $urandom;
               for (int unsigned k = 0; k < len && n < count; k++) begin
                  ramp = (k % period < half) ? k % period : period - k % period;
                  lvl = base + amp * ramp / half + $urandom_range(0, amp / 8 + 1);
                  if (lvl > 65535) lvl = 65535;
                  send_item(lvl[15:0], tm, 1'b0, '0);
                  tm += step + $urandom_range(0, 3);
                  n++;
               end
            end
         endcase
      end
   endtask

   // result side: random stalls, one long hold-off on request
   initial begin
      int unsigned         stall;
      ppd_pkg::result_type exp_r;
      rsp_if.ready <= 1'b0;
      @(negedge reset);
      forever begin
         stall = idle_on ? $urandom_range(0, 8) : 0;
         if (hold_request) begin
            stall = 600;
            hold_request = 1'b0;
         end
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
         results_seen++;
         if (rate_queue.size() == 0) begin
            $display("%0t: unexpected item rate=%0d present=%0b recalc=%0b", $time,
                     rsp_if.pulse_bpm, rsp_if.finger_present, rsp_if.recalculated);
            errors++;
         end else begin
            exp_r = rate_queue.pop_front();
            if (rsp_if.pulse_bpm !== exp_r.pulse_bpm) begin
               $display("%0t: pulse_bpm expected %0d actual %0d", $time,
                        exp_r.pulse_bpm, rsp_if.pulse_bpm);
               errors++;
            end
            if (rsp_if.finger_present !== exp_r.finger_present) begin
               $display("%0t: finger_present expected %0b actual %0b", $time,
                        exp_r.finger_present, rsp_if.finger_present);
               errors++;
            end
            if (rsp_if.recalculated !== exp_r.recalculated) begin
               $display("%0t: recalculated expected %0b actual %0b", $time,
                        exp_r.recalculated, rsp_if.recalculated);
               errors++;
            end
            if (exp_r.recalculated) recalc_seen++;
            if (exp_r.pulse_bpm != 0) rate_seen++;
         end
      end
   end

   initial begin
      logic [31:0] tm;
      logic [15:0] shape [5];
      errors = 0;
      items_sent = 0;
      results_seen = 0;
      recalc_seen = 0;
      rate_seen = 0;
      idle_on = 1'b0;
      hold_request = 1'b0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = ppd_pkg::CSR_PRESENCE_LEVEL;
      csr_wdata = '0;
      req_if.valid = 1'b0;
      req_if.ir_level = '0;
      req_if.time_ms = '0;
      pcfg = '{ppd_pkg::RST_PRESENCE_LEVEL, ppd_pkg::RST_MIN_RATE, ppd_pkg::RST_MAX_RATE,
               ppd_pkg::RST_REFRACTORY_GAP, ppd_pkg::RST_RECALC_PERIOD,
               ppd_pkg::RST_MIN_FILL};
      wr_ptr = 0;
      fill = 0;
      rate_hold = 8'd0;

      // no finger, a level at the threshold (still no finger), full scale, then clear
      add_row(16'd0, 32'd0, 1'b1, 8'd0, 1'b0, 1'b0);
      add_row(16'd5000, 32'd100, 1'b1, 8'd0, 1'b0, 1'b0);
      add_row(16'hFFFF, 32'hFFFF_FFFF, 1'b1, 8'd0, 1'b1, 1'b0);
      add_row(16'd0, 32'd0, 1'b1, 8'd0, 1'b0, 1'b0);
      // pulse every 5 samples at 150 ms steps across the timestamp wrap
      shape = '{16'd6000, 16'd6500, 16'd9000, 16'd6500, 16'd5001};
      tm = 32'hFFFF_FE70;
      for (int k = 0; k < 20; k++) begin
         // fill of 5 recomputes with too few samples
         add_row(shape[k % 5], tm, k == 4, 8'd0, 1'b1, 1'b1);
         tm += 150;
      end
      add_row(16'd4999, 32'd7, 1'b1, 8'd0, 1'b0, 1'b0);

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (stim_rows[i])
         send_item(stim_rows[i].ir_level, stim_rows[i].time_ms,
                   stim_rows[i].typed, stim_rows[i].want);

      idle_on = 1'b1;
      set_config(5000, 30, 220, 5, 5, 10);
      run_stream(70);
      idle_on = 1'b0;
      set_config(0, 0, 255, 0, 0, 0);
      run_stream(70);
      idle_on = 1'b1;
      set_config(65535, 255, 255, 63, 63, 63);
      run_stream(20);
      set_config(1000, 200, 100, 63, 1, 3);
      run_stream(70);
      set_config(20000, 40, 180, 3, 63, 63);
      run_stream(70);
      set_config($urandom_range(0, 30000), $urandom_range(0, 60), $urandom_range(120, 255),
                 $urandom_range(0, 12), $urandom_range(0, 12), $urandom_range(3, 40));
      hold_request = 1'b1;
      run_stream(70);

      drain();
      repeat (300) @(posedge clock);
      $display("Sent %0d items, checked %0d results over six register settings.",
               items_sent, results_seen);
      $display("Saw %0d recomputations and %0d results with a nonzero rate.",
               recalc_seen, rate_seen);
      if (errors == 0 && rate_queue.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0t: %0d mismatches, %0d results missing", $time, errors,
                  rate_queue.size());
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
